### hw/rtl/gss_pkg.sv
// Shared constants, codes and types of the gradient stop setup block.
package gss_pkg;

  localparam int STOP_DEPTH = 16;
  localparam int IDX_W      = $clog2(STOP_DEPTH);
  localparam int CNT_W      = $clog2(STOP_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 3'd6;

  localparam logic [1:0] ST_STOP   = 2'd0;
  localparam logic [1:0] ST_GEOM   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_ZERO   = 2'd3;

  localparam logic       MODE_LINEAR = 1'b0;
  localparam logic [7:0] ALPHA_FULL  = 8'hff;
  localparam logic [15:0] ONE_Q15    = 16'd32768;

  typedef struct packed {
    logic        num_neg;
    logic [63:0] num_mag;
    logic [61:0] den;
    logic [5:0]  extra;
    logic        rnd;
  } gss_div_req_t;

endpackage

### hw/rtl/gss_if.sv
// Request channels: stop input and result output.
interface gss_stop_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] stop_value;
  logic [31:0]        color;
  logic               last_stop;
  modport source (output valid, stop_value, color, last_stop, input ready);
  modport sink (input valid, stop_value, color, last_stop, output ready);
endinterface

interface gss_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        stop_value_res;
  logic [31:0]        color_res;
  logic signed [47:0] coef_a;
  logic signed [47:0] coef_b;
  logic signed [47:0] coef_c;
  logic               opaque;
  logic               last;
  modport source (output valid, status, stop_value_res, color_res, coef_a, coef_b, coef_c,
                  opaque, last, input ready);
  modport sink (input valid, status, stop_value_res, color_res, coef_a, coef_b, coef_c,
                opaque, last, output ready);
endinterface

### hw/rtl/gss_div.sv
// Bit-serial restoring divider with rounding and 48-bit saturation.
module gss_div
  import gss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gss_div_req_t       req_i,
  output logic               done_o,
  output logic signed [47:0] res_o
);

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] mag_q;
  logic [61:0] den_q;
  logic [61:0] rem_q;
  logic [49:0] quo_q;
  logic        sat_q, neg_q, rnd_q;

  logic [62:0] rem2;
  logic        qbit;
  logic [49:0] rq;
  logic        big;

  assign rem2 = {rem_q, mag_q[63]};
  assign qbit = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd1);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64 + {1'b0, req_i.extra};
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      mag_q <= req_i.num_mag;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
      neg_q <= req_i.num_neg;
      rnd_q <= req_i.rnd;
    end else if (busy_q) begin
      mag_q <= {mag_q[62:0], 1'b0};
      rem_q <= qbit ? 62'(rem2 - {1'b0, den_q}) : rem2[61:0];
      quo_q <= {quo_q[48:0], qbit};
      if (quo_q[49]) sat_q <= 1'b1;
    end
  end

  always_comb begin
    rq  = rnd_q ? 50'((51'(quo_q) + 51'd1) >> 1) : quo_q;
    big = sat_q || (rq >= 50'h0800000000000);
    if (neg_q) res_o = big ? 48'sh800000000000 : -$signed(rq[47:0]);
    else       res_o = big ? 48'sh7fffffffffff : $signed(rq[47:0]);
  end

  assign done_o = done_q;

endmodule

### hw/rtl/gradient_stop_setup.sv
// Gradient stop setup: stop store, renormalization, geometry coefficients.
// Sequence: a stop that is not last is stored and taken. The last stop adds a check state,
// then linear setup runs its multiply steps and the coefficient divides (prescale s = 0..2,
// no divides for a zero axis), or radial setup its multiply steps; then per stop a read, a
// renormalizing divide where needed and the stop item, then the geometry item. A rejected list emits a reject item.
// Reset is asynchronous active low: list state and config registers to defaults, store undefined.
module gradient_stop_setup
  import gss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gss_stop_if.sink              in_if,
  gss_res_if.source             out_if
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_REJ   = 4'd2;
  localparam logic [3:0] S_GEO   = 4'd3;
  localparam logic [3:0] S_GDIV  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_NRM   = 4'd6;
  localparam logic [3:0] S_SDIV  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_GEMIT = 4'd9;

  logic [3:0] state_q;
  logic [3:0] step_q;

  logic               mode_q;
  logic signed [31:0] ax_q, ay_q, bx_q, by_q, rad_q;
  logic [15:0]        eps_q;

  logic [15:0] stop_mem [STOP_DEPTH];
  logic [31:0] color_mem [STOP_DEPTH];
  logic [15:0] rd_stop_q;
  logic [31:0] rd_color_q;

  logic [CNT_W-1:0] cnt_q;
  logic             inv_q;
  logic [7:0]       alpha_q;
  logic [15:0]      first_q, prev_q;

  logic        ren_q;
  logic [15:0] base_q, span_q;
  logic [IDX_W-1:0] idx_q;
  logic [15:0] val_q;

  logic signed [65:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [30:0] wx_q, wy_q;
  logic [1:0]         sh_q;
  logic [61:0]        d_q;
  logic signed [63:0] p_q;
  logic               zero_q;
  logic signed [47:0] ca_q, cb_q, cc_q;

  logic               ov_q;
  logic [1:0]         o_status_q;
  logic [15:0]        o_stop_q;
  logic [31:0]        o_color_q;
  logic signed [47:0] o_a_q, o_b_q, o_c_q;
  logic               o_opq_q, o_last_q;

  logic               div_start;
  gss_div_req_t       div_req;
  logic               div_done;
  logic signed [47:0] div_res;

  logic in_take, out_free, out_load, opq, is_last, is_first;
  logic signed [32:0] vx, vy, wxs, wys;
  logic [1:0] sh;

  assign in_if.ready = (state_q == S_LOAD);
  assign in_take     = in_if.valid && in_if.ready;
  assign out_free    = !ov_q || out_if.ready;
  assign out_load    = out_free &&
                       (state_q == S_EMIT || state_q == S_GEMIT || state_q == S_REJ);
  assign opq         = (alpha_q == ALPHA_FULL);
  assign is_last     = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
  assign is_first    = (idx_q == '0);

  // axis vector and prescale
  assign vx = 33'(ex_q) - 33'(sx_q);
  assign vy = 33'(ey_q) - 33'(sy_q);
  always_comb begin
    if ((vx[32:30] == 3'b000 || vx[32:30] == 3'b111) &&
        (vy[32:30] == 3'b000 || vy[32:30] == 3'b111))     sh = 2'd0;
    else if ((vx[32:31] == 2'b00 || vx[32:31] == 2'b11) &&
             (vy[32:31] == 2'b00 || vy[32:31] == 2'b11))  sh = 2'd1;
    else                                                   sh = 2'd2;
    wxs = vx >>> sh;
    wys = vy >>> sh;
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_GEO) begin
      if (mode_q != MODE_LINEAR) begin
        mul_a = 33'(rad_q);
        mul_b = $signed({17'd0, prev_q});
      end else begin
        case (step_q)
          4'd0: begin
            mul_a = 33'(bx_q) - 33'(ax_q); mul_b = $signed({17'd0, first_q});
          end
          4'd1: begin
            mul_a = 33'(by_q) - 33'(ay_q); mul_b = $signed({17'd0, first_q});
          end
          4'd2: begin
            mul_a = 33'(bx_q) - 33'(ax_q); mul_b = $signed({17'd0, prev_q});
          end
          4'd3: begin
            mul_a = 33'(by_q) - 33'(ay_q); mul_b = $signed({17'd0, prev_q});
          end
          4'd6: begin mul_a = 33'(wx_q); mul_b = 33'(wx_q); end
          4'd7: begin mul_a = 33'(wy_q); mul_b = 33'(wy_q); end
          4'd8: begin mul_a = 33'(wx_q); mul_b = 33'(sx_q); end
          4'd9: begin mul_a = 33'(wy_q); mul_b = 33'(sy_q); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
    end
  end

  // divider request
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    if (state_q == S_GEO && mode_q == MODE_LINEAR) begin
      div_req.den = d_q;
      div_req.rnd = 1'b1;
      case (step_q)
        4'd11: begin
          div_start        = (d_q != '0);
          div_req.num_neg  = wx_q[30];
          div_req.num_mag  = 64'(wx_q[30] ? -33'(wx_q) : 33'(wx_q));
          div_req.extra    = 6'd41 - 6'(sh_q);
        end
        4'd12: begin
          div_start        = 1'b1;
          div_req.num_neg  = wy_q[30];
          div_req.num_mag  = 64'(wy_q[30] ? -33'(wy_q) : 33'(wy_q));
          div_req.extra    = 6'd41 - 6'(sh_q);
        end
        4'd13: begin
          div_start        = 1'b1;
          div_req.num_neg  = !p_q[63] && (p_q != '0);
          div_req.num_mag  = p_q[63] ? 64'(-p_q) : 64'(p_q);
          div_req.extra    = 6'd25 - 6'(sh_q);
        end
        default: div_start = 1'b0;
      endcase
    end else if (state_q == S_NRM) begin
      div_start       = ren_q && !is_last && !(is_first && mode_q == MODE_LINEAR);
      div_req.num_neg = 1'b0;
      div_req.num_mag = 64'({16'(rd_stop_q - base_q), 15'd0}) + 64'(span_q >> 1);
      div_req.den     = 62'(span_q);
      div_req.extra   = 6'd0;
      div_req.rnd     = 1'b0;
    end
  end

  gss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .req_i  (div_req),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
      ax_q   <= '0;
      ay_q   <= '0;
      bx_q   <= '0;
      by_q   <= '0;
      rad_q  <= '0;
      eps_q  <= 16'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:    mode_q <= cfg_data_i[0];
        CFG_A_X:     ax_q   <= $signed(cfg_data_i);
        CFG_A_Y:     ay_q   <= $signed(cfg_data_i);
        CFG_B_X:     bx_q   <= $signed(cfg_data_i);
        CFG_B_Y:     by_q   <= $signed(cfg_data_i);
        CFG_RADIUS:  rad_q  <= $signed(cfg_data_i);
        CFG_EPSILON: eps_q  <= cfg_data_i[15:0];
        default:     mode_q <= mode_q;
      endcase
    end
  end

  // stop store
  always_ff @(posedge clk_i) begin
    if (in_take && cnt_q < CNT_W'(STOP_DEPTH)) begin
      stop_mem[cnt_q[IDX_W-1:0]]  <= in_if.stop_value[15:0];
      color_mem[cnt_q[IDX_W-1:0]] <= in_if.color;
    end
    rd_stop_q  <= stop_mem[idx_q];
    rd_color_q <= color_mem[idx_q];
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      step_q  <= '0;
      cnt_q   <= '0;
      inv_q   <= 1'b0;
      alpha_q <= 8'hff;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_take) begin
            alpha_q <= alpha_q & in_if.color[31:24];
            if (in_if.stop_value[16] || in_if.stop_value > 17'sd32768) inv_q <= 1'b1;
            if (cnt_q >= CNT_W'(STOP_DEPTH)) begin
              inv_q <= 1'b1;
            end else begin
              if (cnt_q != '0 && $signed({1'b0, prev_q}) > in_if.stop_value) inv_q <= 1'b1;
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (in_if.last_stop) state_q <= S_CHK;
          end
        end
        S_CHK: begin
          step_q <= '0;
          idx_q  <= '0;
          state_q <= (inv_q || cnt_q == '0) ? S_REJ : S_GEO;
        end
        S_REJ: begin
          if (out_free) begin
            cnt_q   <= '0;
            inv_q   <= 1'b0;
            alpha_q <= 8'hff;
            state_q <= S_LOAD;
          end
        end
        S_GEO: begin
          if (mode_q != MODE_LINEAR) begin
            if (step_q == 4'd14) state_q <= S_RD;
            else                 step_q  <= (step_q == 4'd1) ? 4'd14 : step_q + 4'd1;
          end else begin
            case (step_q)
              4'd11: begin
                step_q <= (d_q == '0) ? 4'd14 : 4'd12;
                if (d_q != '0) state_q <= S_GDIV;
              end
              4'd12, 4'd13: begin
                step_q  <= step_q + 4'd1;
                state_q <= S_GDIV;
              end
              4'd14:   state_q <= S_RD;
              default: step_q  <= step_q + 4'd1;
            endcase
          end
        end
        S_GDIV: begin
          if (div_done) state_q <= S_GEO;
        end
        S_RD: state_q <= S_NRM;
        S_NRM: state_q <= div_start ? S_SDIV : S_EMIT;
        S_SDIV: begin
          if (div_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (is_last) begin
              state_q <= S_GEMIT;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_RD;
            end
          end
        end
        S_GEMIT: begin
          if (out_free) begin
            cnt_q   <= '0;
            inv_q   <= 1'b0;
            alpha_q <= 8'hff;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_take && cnt_q < CNT_W'(STOP_DEPTH)) begin
      prev_q <= in_if.stop_value[15:0];
      if (cnt_q == '0) first_q <= in_if.stop_value[15:0];
    end
    if (state_q == S_CHK) begin
      zero_q <= 1'b0;
      if (mode_q == MODE_LINEAR) begin
        base_q <= first_q;
        span_q <= prev_q - first_q;
        ren_q  <= (first_q != '0 || prev_q != ONE_Q15) && (prev_q - first_q) > eps_q;
      end else begin
        base_q <= '0;
        span_q <= prev_q;
        ren_q  <= (prev_q != ONE_Q15) && (prev_q > eps_q);
      end
    end
    if (state_q == S_GEO) begin
      if (mode_q != MODE_LINEAR) begin
        if (step_q == 4'd1) begin
          ca_q <= {{8{ax_q[31]}}, ax_q, 8'd0};
          cb_q <= {{8{ay_q[31]}}, ay_q, 8'd0};
          if (ren_q) cc_q <= {{8{prod_q[46]}}, prod_q[46:15], 8'd0};
          else       cc_q <= {{8{rad_q[31]}}, rad_q, 8'd0};
        end
      end else begin
        case (step_q)
          4'd1: sx_q <= ren_q ? ax_q + prod_q[46:15] : ax_q;
          4'd2: sy_q <= ren_q ? ay_q + prod_q[46:15] : ay_q;
          4'd3: ex_q <= ren_q ? ax_q + prod_q[46:15] : bx_q;
          4'd4: ey_q <= ren_q ? ay_q + prod_q[46:15] : by_q;
          4'd5: begin
            wx_q <= wxs[30:0];
            wy_q <= wys[30:0];
            sh_q <= sh;
          end
          4'd7:  d_q <= prod_q[61:0];
          4'd8:  d_q <= d_q + prod_q[61:0];
          4'd9:  p_q <= prod_q[63:0];
          4'd10: p_q <= p_q + prod_q[63:0];
          4'd11: begin
            if (d_q == '0) begin
              zero_q <= 1'b1;
              ca_q   <= '0;
              cb_q   <= '0;
              cc_q   <= '0;
            end
          end
          default: zero_q <= zero_q;
        endcase
      end
    end
    if (state_q == S_GDIV && div_done) begin
      case (step_q)
        4'd12:   ca_q <= div_res;
        4'd13:   cb_q <= div_res;
        default: cc_q <= div_res;
      endcase
    end
    if (state_q == S_NRM) begin
      if (!ren_q)                                  val_q <= rd_stop_q;
      else if (is_last)                            val_q <= ONE_Q15;
      else if (is_first && mode_q == MODE_LINEAR)  val_q <= '0;
    end
    if (state_q == S_SDIV && div_done) val_q <= div_res[15:0];
    if (state_q == S_EMIT && out_free) begin
      o_status_q <= ST_STOP;
      o_stop_q   <= val_q;
      o_color_q  <= rd_color_q;
      o_a_q      <= '0;
      o_b_q      <= '0;
      o_c_q      <= '0;
      o_opq_q    <= 1'b0;
      o_last_q   <= 1'b0;
    end
    if (state_q == S_GEMIT && out_free) begin
      o_status_q <= zero_q ? ST_ZERO : ST_GEOM;
      o_stop_q   <= '0;
      o_color_q  <= '0;
      o_a_q      <= ca_q;
      o_b_q      <= cb_q;
      o_c_q      <= cc_q;
      o_opq_q    <= opq;
      o_last_q   <= 1'b1;
    end
    if (state_q == S_REJ && out_free) begin
      o_status_q <= ST_REJECT;
      o_stop_q   <= '0;
      o_color_q  <= '0;
      o_a_q      <= '0;
      o_b_q      <= '0;
      o_c_q      <= '0;
      o_opq_q    <= 1'b0;
      o_last_q   <= 1'b1;
    end
  end

  assign out_if.valid          = ov_q;
  assign out_if.status         = o_status_q;
  assign out_if.stop_value_res = o_stop_q;
  assign out_if.color_res      = o_color_q;
  assign out_if.coef_a         = o_a_q;
  assign out_if.coef_b         = o_b_q;
  assign out_if.coef_c         = o_c_q;
  assign out_if.opaque         = o_opq_q;
  assign out_if.last           = o_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STOP_DEPTH))
    else $error("stop count beyond store depth");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT || state_q == S_GEMIT || state_q == S_REJ) && out_free) |=> ov_q)
    else $error("result not loaded into output register");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_GDIV || state_q == S_SDIV))
    else $error("divider finished outside a wait state");

endmodule

### bench/tb_top.sv
// Self-checking testbench of gradient_stop_setup: directed and random stop lists checked
// against a predictor.
module tb_top;
  import gss_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_ITEMS   = 145;

  typedef struct {
    logic [1:0]         status;
    logic [15:0]        pos;
    logic [31:0]        color;
    logic signed [47:0] coef_a;
    logic signed [47:0] coef_b;
    logic signed [47:0] coef_c;
    logic               opaque;
    logic               last;
  } grad_res_t;

  typedef struct {
    int        pos;
    bit [31:0] color;
    bit        last;
    bit        rejects;
  } stop_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gss_stop_if stop_ch ();
  gss_res_if  res_ch ();

  gradient_stop_setup i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (stop_ch.sink),
    .out_if     (res_ch.source)
  );

  // predictor copy of registers and list state
  logic               grad_mode;
  longint             pa_x, pa_y, pb_x, pb_y, rad;
  int unsigned        eps;
  bit [15:0]          pos_store [STOP_DEPTH];
  bit [31:0]          col_store [STOP_DEPTH];
  int                 list_len;
  bit                 list_bad;
  bit [31:0]          alpha_and;

  grad_res_t expected_q[$];
  bit        failed;
  int        idle_cycles;
  int        sent_items;
  int        stall_level;
  int        gap_level;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint coef_div(longint num, longint unsigned den, int k);
    longint unsigned lim;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned r;
    bit neg;
    lim = 64'd1 << 47;
    neg = num < 0;
    mag = neg ? 64'd0 - longint'(num) : num;
    q = mag / den;
    r = mag % den;
    if (q > lim * 4) q = lim * 4;
    for (int i = 0; i < k + 1 && q <= lim * 4; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    q = (q + 1) >> 1;
    if (neg) return (q >= lim) ? -longint'(lim) : -longint'(q);
    return (q >= lim) ? longint'(lim - 1) : longint'(q);
  endfunction

  function automatic void clear_list();
    list_len  = 0;
    list_bad  = 1'b0;
    alpha_and = '1;
  endfunction

  function automatic grad_res_t mk_res(logic [1:0] st, logic [15:0] p, logic [31:0] c,
                                        longint a, longint b, longint cc, logic o, logic l);
    grad_res_t x;
    x.status = st; x.pos = p; x.color = c;
    x.coef_a = a[47:0]; x.coef_b = b[47:0]; x.coef_c = cc[47:0];
    x.opaque = o; x.last = l;
    return x;
  endfunction

  // Stores one stop; on the last stop appends the expected results to expected_q.
  function automatic void predict_stop(logic signed [16:0] stop, logic [31:0] color,
                                       logic last_stop, bit typed_reject);
    longint      sv;
    int unsigned st [STOP_DEPTH];
    int unsigned n, f, l, span;
    logic        opq;
    longint      sx, sy, ex, ey, wx, wy, p, r, lim30;
    longint unsigned d;
    int          s;
    sv = stop;
    alpha_and &= color;
    if (sv < 0 || sv > 32768) list_bad = 1'b1;
    if (list_len >= STOP_DEPTH) begin
      list_bad = 1'b1;
    end else begin
      if (list_len > 0 && longint'(pos_store[list_len-1]) > sv) list_bad = 1'b1;
      pos_store[list_len] = sv[15:0];
      col_store[list_len] = color;
      list_len++;
    end
    if (!last_stop) return;
    if (typed_reject) begin
      expected_q.push_back(mk_res(ST_REJECT, 16'd0, 32'd0, 0, 0, 0, 1'b0, 1'b1));
      clear_list();
      return;
    end
    if (list_bad || list_len == 0) begin
      expected_q.push_back(mk_res(ST_REJECT, 16'd0, 32'd0, 0, 0, 0, 1'b0, 1'b1));
      clear_list();
      return;
    end
    n = list_len;
    for (int i = 0; i < n; i++) st[i] = pos_store[i];
    opq = alpha_and[31:24] == ALPHA_FULL;
    if (grad_mode == MODE_LINEAR) begin
      sx = pa_x; sy = pa_y; ex = pb_x; ey = pb_y;
      f = st[0];
      l = st[n-1];
      s = 0;
      lim30 = 64'sd1 <<< 30;
      if ((f != 0 || l != 32768) && (l - f) > eps) begin
        span = l - f;
        sx = pa_x + (((pb_x - pa_x) * longint'(f)) >>> 15);
        sy = pa_y + (((pb_y - pa_y) * longint'(f)) >>> 15);
        ex = pa_x + (((pb_x - pa_x) * longint'(l)) >>> 15);
        ey = pa_y + (((pb_y - pa_y) * longint'(l)) >>> 15);
        st[0] = 0;
        st[n-1] = 32768;
        if (n > 2) begin
          for (int i = 1; i < n - 1; i++) st[i] = ((st[i] - f) * 32768 + span / 2) / span;
          for (int i = 1; i < n - 1; i++) if (st[i] < st[i-1]) st[i] = st[i-1];
          for (int i = n - 2; i >= 1; i--) if (st[i] > st[i+1]) st[i] = st[i+1];
        end
      end
      wx = ex - sx;
      wy = ey - sy;
      while (s < 3 && (wx < -lim30 || wx >= lim30 || wy < -lim30 || wy >= lim30)) begin
        s++;
        wx = (ex - sx) >>> s;
        wy = (ey - sy) >>> s;
      end
      d = wx * wx + wy * wy;
      for (int i = 0; i < n; i++)
        expected_q.push_back(mk_res(ST_STOP, st[i][15:0], col_store[i], 0, 0, 0, 1'b0, 1'b0));
      if (d == 0) begin
        expected_q.push_back(mk_res(ST_ZERO, 16'd0, 32'd0, 0, 0, 0, opq, 1'b1));
      end else begin
        p = wx * sx + wy * sy;
        expected_q.push_back(mk_res(ST_GEOM, 16'd0, 32'd0, coef_div(wx, d, 40 - s),
                                    coef_div(wy, d, 40 - s), coef_div(-p, d, 24 - s),
                                    opq, 1'b1));
      end
    end else begin
      r = rad;
      l = st[n-1];
      if (l != 32768 && l > eps) begin
        st[n-1] = 32768;
        r = (rad * longint'(l)) >>> 15;
        for (int i = 0; i + 1 < n; i++) st[i] = (st[i] * 32768 + l / 2) / l;
        for (int i = 1; i + 1 < n; i++) if (st[i] < st[i-1]) st[i] = st[i-1];
        for (int i = n - 1; i >= 1; i--) if (st[i-1] > st[i]) st[i-1] = st[i];
      end
      for (int i = 0; i < n; i++)
        expected_q.push_back(mk_res(ST_STOP, st[i][15:0], col_store[i], 0, 0, 0, 1'b0, 1'b0));
      expected_q.push_back(mk_res(ST_GEOM, 16'd0, 32'd0, pa_x * 256, pa_y * 256, r * 256,
                                  opq, 1'b1));
    end
    clear_list();
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      CFG_MODE:    grad_mode = data[0];
      CFG_A_X:     pa_x = longint'(signed'(data));
      CFG_A_Y:     pa_y = longint'(signed'(data));
      CFG_B_X:     pb_x = longint'(signed'(data));
      CFG_B_Y:     pb_y = longint'(signed'(data));
      CFG_RADIUS:  rad = longint'(signed'(data));
      CFG_EPSILON: eps = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(logic m, logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                            logic [31:0] by, logic [31:0] r, logic [15:0] e);
    write_reg(CFG_MODE, {31'd0, m});
    write_reg(CFG_A_X, ax);
    write_reg(CFG_A_Y, ay);
    write_reg(CFG_B_X, bx);
    write_reg(CFG_B_Y, by);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_EPSILON, {16'd0, e});
  endtask

  function automatic int pick_gap(int level);
    if (level == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic send_stop(int pos, logic [31:0] color, logic last_stop, bit typed_reject);
    int gap;
    gap = pick_gap(gap_level);
    if (gap > 0) begin
      stop_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    stop_ch.valid      = 1'b1;
    stop_ch.stop_value = pos[16:0];
    stop_ch.color      = color;
    stop_ch.last_stop  = last_stop;
    do @(posedge clk_i); while (!stop_ch.ready);
    predict_stop(pos[16:0], color, last_stop, typed_reject);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    stop_ch.valid = 1'b0;
    wait (expected_q.size() == 0);
    @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic bit [31:0] rand_color();
    bit [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 2) != 0) c[31:24] = 8'hff;
    return c;
  endfunction

  task automatic random_list();
    int q[$];
    int len, kind;
    kind = $urandom_range(0, 9);
    len = (kind == 9) ? $urandom_range(STOP_DEPTH + 1, STOP_DEPTH + 3)
                      : ($urandom_range(0, 3) == 0 ? $urandom_range(1, STOP_DEPTH)
                                                   : $urandom_range(1, 5));
    for (int i = 0; i < len; i++) begin
      if (kind == 8) q.push_back(int'($urandom_range(0, 131071)) - 65536);
      else if (kind == 7) q.push_back($urandom_range(1000, 1010));
      else q.push_back($urandom_range(0, 32768));
    end
    if (kind < 8) q.sort();
    if (kind == 6 && len > 1) begin
      q[0] = 0;
      q[len-1] = 32768;
    end
    if (kind == 5) q[len-1] = $urandom_range(0, 8);
    if (kind == 4 && len > 1) begin
      q[len-1] = $urandom_range(0, 32768);
      q[0] = $urandom_range(0, 32768);
    end
    for (int i = 0; i < len; i++) send_stop(q[i], rand_color(), i == len - 1, 1'b0);
  endtask

  stop_row_t directed_rows[$] = '{
    '{0, 32'hffffffff, 1'b1, 1'b0},
    '{-65536, 32'h00000000, 1'b1, 1'b1},
    '{32769, 32'hff000000, 1'b1, 1'b1},
    '{65535, 32'hffffffff, 1'b1, 1'b1},
    '{-1, 32'h12345678, 1'b1, 1'b1},
    '{20000, 32'hffffffff, 1'b0, 1'b0},
    '{10000, 32'hffffffff, 1'b1, 1'b1},
    '{0, 32'hff00ff00, 1'b0, 1'b0},
    '{16384, 32'hff0000ff, 1'b0, 1'b0},
    '{32768, 32'hffffffff, 1'b1, 1'b0},
    '{1000, 32'h80ffffff, 1'b0, 1'b0},
    '{3000, 32'hff123456, 1'b0, 1'b0},
    '{2000, 32'hffffffff, 1'b1, 1'b1},
    '{4096, 32'hffabcdef, 1'b0, 1'b0},
    '{4096, 32'hfe000001, 1'b0, 1'b0},
    '{8192, 32'hffffffff, 1'b1, 1'b0},
    '{100, 32'h00ffffff, 1'b0, 1'b0},
    '{104, 32'hffffffff, 1'b1, 1'b0},
    '{32768, 32'h55aa55aa, 1'b1, 1'b0}
  };

  // result checker
  always @(posedge clk_i) begin
    grad_res_t exp_res;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result, status %0d", res_ch.status);
        failed = 1'b1;
      end else begin
        exp_res = expected_q.pop_front();
        if (res_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_ch.status);
          failed = 1'b1;
        end
        if (res_ch.stop_value_res !== exp_res.pos) begin
          $error("stop_value_res: expected %0d, got %0d", exp_res.pos, res_ch.stop_value_res);
          failed = 1'b1;
        end
        if (res_ch.color_res !== exp_res.color) begin
          $error("color_res: expected %h, got %h", exp_res.color, res_ch.color_res);
          failed = 1'b1;
        end
        if (res_ch.coef_a !== exp_res.coef_a) begin
          $error("coef_a: expected %0d, got %0d", exp_res.coef_a, res_ch.coef_a);
          failed = 1'b1;
        end
        if (res_ch.coef_b !== exp_res.coef_b) begin
          $error("coef_b: expected %0d, got %0d", exp_res.coef_b, res_ch.coef_b);
          failed = 1'b1;
        end
        if (res_ch.coef_c !== exp_res.coef_c) begin
          $error("coef_c: expected %0d, got %0d", exp_res.coef_c, res_ch.coef_c);
          failed = 1'b1;
        end
        if (res_ch.opaque !== exp_res.opaque) begin
          $error("opaque: expected %0d, got %0d", exp_res.opaque, res_ch.opaque);
          failed = 1'b1;
        end
        if (res_ch.last !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, res_ch.last);
          failed = 1'b1;
        end
      end
    end
  end

  // result-side stalls
  always @(negedge clk_i) begin
    if (stall_level == 0) res_ch.ready <= 1'b1;
    else if ($urandom_range(0, 39) == 0) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(0, 3) != 0) || (res_ch.ready && $urandom_range(0, 1));
  end

  always @(posedge clk_i) begin
    if ((stop_ch.valid && stop_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] eps_pick [5] = '{16'd0, 16'd8, 16'd32768, 16'd65535, 16'd200};
    int phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    stop_ch.valid = 1'b0;
    stop_ch.stop_value = '0;
    stop_ch.color = '0;
    stop_ch.last_stop = 1'b0;
    res_ch.ready = 1'b0;
    failed = 1'b0;
    idle_cycles = 0;
    sent_items = 0;
    stall_level = 1;
    gap_level = 1;
    grad_mode = MODE_LINEAR;
    pa_x = 0; pa_y = 0; pb_x = 0; pb_y = 0; rad = 0;
    eps = 8;
    clear_list();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values first, then a plain unit axis
    for (int i = 0; i < directed_rows.size(); i++) begin
      if (i == 1) begin
        drain();
        set_config(MODE_LINEAR, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 16'd8);
      end
      send_stop(directed_rows[i].pos, directed_rows[i].color, directed_rows[i].last,
                directed_rows[i].rejects);
    end
    drain();

    phase = 0;
    while (sent_items < RANDOM_ITEMS + directed_rows.size()) begin
      stall_level = phase % 3;
      gap_level = (phase + 1) % 3;
      case (phase % 5)
        0: set_config(1'b1, 32'h8000_0000, 32'h7fff_ffff, $urandom, $urandom,
                      32'h7fff_ffff, eps_pick[$urandom_range(0, 4)]);
        1: set_config(MODE_LINEAR, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, $urandom, eps_pick[phase % 5]);
        2: set_config(MODE_LINEAR, 32'h0001_0000, 32'hfffe_0000, 32'h0001_0000,
                      32'hfffe_0000, 32'h8000_0000, eps_pick[$urandom_range(0, 4)]);
        3: set_config(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 65535));
        default: set_config(MODE_LINEAR, $signed($urandom) >>> $urandom_range(0, 14),
                            $signed($urandom) >>> $urandom_range(0, 14),
                            $signed($urandom) >>> $urandom_range(0, 14),
                            $signed($urandom) >>> $urandom_range(0, 14), $urandom,
                            eps_pick[$urandom_range(0, 4)]);
      endcase
      repeat ($urandom_range(3, 6)) random_list();
      drain();
      phase++;
    end

    if (failed) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/gss_pkg.sv
hw/rtl/gss_if.sv
hw/rtl/gss_div.sv
hw/rtl/gradient_stop_setup.sv
bench/tb_top.sv
